// ===== rtl/core/obrf_pkg.sv =====
package obrf_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned FILL_W = 9;
    localparam int unsigned ERR_W  = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERRUN = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY   = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_BYTE = 8'hFF;

    // where the result byte comes from
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_ONES = 2'd1;
    localparam logic [1:0] RD_MEM  = 2'd2;

    typedef struct packed {
        logic [1:0]        rd_sel;
        logic              ok;
        logic [ERR_W-1:0]  last_error;
        logic [FILL_W-1:0] fill_count;
        logic              buf_empty;
        logic              is_full;
    } t_status;

endpackage

// ===== rtl/core/obrf_ram.sv =====
module obrf_ram
    import obrf_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned IW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [IW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/core/obrf_ctrl.sv =====
module obrf_ctrl
    import obrf_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned IW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_op,
    output logic          o_mem_we,
    output logic [IW-1:0] o_mem_waddr,
    output logic          o_mem_re,
    output logic [IW-1:0] o_mem_raddr,
    output t_status       o_status
);

    localparam int unsigned FW = IW + 1;

    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic [IW-1:0]    r_wr_idx, n_wr_idx;
    logic             r_full, n_full;
    logic             r_empty, n_empty;
    logic [ERR_W-1:0] r_err, n_err;
    logic             ok;
    logic [1:0]       rd_sel;
    logic             mem_we, mem_re;
    logic [FW-1:0]    fill;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_full   = r_full;
        n_empty  = r_empty;
        n_err    = r_err;
        ok       = 1'b1;
        rd_sel   = RD_ZERO;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        if (i_accept) begin
            if (i_op == OP_WRITE) begin
                // full: drop the oldest byte
                if (r_full) begin
                    n_err    = ERR_OVERRUN;
                    ok       = 1'b0;
                    n_rd_idx = next_idx(r_rd_idx);
                end
                mem_we   = 1'b1;
                n_wr_idx = next_idx(r_wr_idx);
                if (n_wr_idx == n_rd_idx) begin
                    n_full = 1'b1;
                end
                n_empty = 1'b0;
            end else if (r_empty) begin
                n_err  = ERR_EMPTY;
                ok     = 1'b0;
                rd_sel = RD_ONES;
            end else begin
                mem_re   = 1'b1;
                rd_sel   = RD_MEM;
                n_rd_idx = next_idx(r_rd_idx);
                if (n_rd_idx == r_wr_idx) begin
                    n_empty = 1'b1;
                end
                n_full = 1'b0;
            end
        end
    end

    always_comb begin
        if (n_full) begin
            fill = FW'(DEPTH);
        end else if (n_wr_idx >= n_rd_idx) begin
            fill = {1'b0, n_wr_idx} - {1'b0, n_rd_idx};
        end else begin
            fill = FW'(DEPTH) - {1'b0, n_rd_idx} + {1'b0, n_wr_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_full   <= 1'b0;
            r_empty  <= 1'b1;
            r_err    <= ERR_NONE;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_full   <= n_full;
            r_empty  <= n_empty;
            r_err    <= n_err;
        end
    end

    assign o_mem_we    = mem_we;
    assign o_mem_waddr = r_wr_idx;
    assign o_mem_re    = mem_re;
    assign o_mem_raddr = r_rd_idx;

    assign o_status.rd_sel     = rd_sel;
    assign o_status.ok         = ok;
    assign o_status.last_error = n_err;
    assign o_status.fill_count = FILL_W'(fill);
    assign o_status.buf_empty  = n_empty;
    assign o_status.is_full    = n_full;

endmodule

// ===== rtl/core/overwriting_byte_ring_fifo_core.sv =====
// Byte ring FIFO of DEPTH entries that overwrites its oldest byte when a write
// finds it full. Each transaction is one write or one read and yields exactly
// one result: the byte read, a success flag, the sticky last error, the fill
// count (low 9 bits) and the empty/full flags. One transaction is taken every
// clock cycle while o_stall is low; its result passes first through the
// registered read port of the byte memory and then through the output
// register. Both stages hold under o_stall / i_stall back-pressure. No clearing
// pass is needed after reset: entries are only read after they are written.
module overwriting_byte_ring_fifo_core
    import obrf_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_op,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_rd_data,
    output logic              o_ok,
    output logic [ERR_W-1:0]  o_last_error,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_is_empty_flag,
    output logic              o_is_full_flag
);

    localparam int unsigned IW = $clog2(DEPTH);

    logic              accept;
    logic              s1_adv;
    logic              s2_free;
    logic              mem_we, mem_re;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    t_status           status;
    logic [DATA_W-1:0] n_rd_data;

    logic              r_v1;
    t_status           r_s1;
    logic              r_v2;
    t_status           r_s2;
    logic [DATA_W-1:0] r_rd_data;

    assign s2_free = !r_v2 || !i_stall;
    assign s1_adv  = r_v1 && s2_free;
    assign o_stall = r_v1 && !s2_free;
    assign accept  = i_valid && !o_stall;

    obrf_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_op),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_status    (status)
    );

    obrf_ram #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_wr_data),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        unique case (r_s1.rd_sel)
            RD_MEM:  n_rd_data = mem_rdata;
            RD_ONES: n_rd_data = EMPTY_BYTE;
            default: n_rd_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv) begin
                r_v2 <= 1'b1;
            end else if (!i_stall) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= status;
        end
        if (s1_adv) begin
            r_s2      <= r_s1;
            r_rd_data <= n_rd_data;
        end
    end

    assign o_valid         = r_v2;
    assign o_rd_data       = r_rd_data;
    assign o_ok            = r_s2.ok;
    assign o_last_error    = r_s2.last_error;
    assign o_fill_count    = r_s2.fill_count;
    assign o_is_empty_flag = r_s2.buf_empty;
    assign o_is_full_flag  = r_s2.is_full;

endmodule

// ===== rtl/core/obrf_checker.sv =====
module obrf_checker
    import obrf_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] i_rd_data,
    input logic              i_ok,
    input logic [ERR_W-1:0]  i_last_error,
    input logic [FILL_W-1:0] i_fill_count,
    input logic              i_is_empty_flag,
    input logic              i_is_full_flag
);

    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_is_empty_flag && i_is_full_flag))
        else $error("empty and full reported together");

    a_empty_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_empty_flag |-> i_fill_count == '0)
        else $error("empty with nonzero fill count");

    a_full_fill_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_full_flag |-> i_fill_count == FILL_W'(DEPTH))
        else $error("full without depth fill count");

    a_fail_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> i_last_error != ERR_NONE)
        else $error("failed transaction without error code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_rd_data)
            && $stable(i_fill_count))
        else $error("stalled result changed");

endmodule

bind overwriting_byte_ring_fifo_core obrf_checker #(
    .DEPTH (DEPTH)
) u_obrf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_valid),
    .i_out_stall     (i_stall),
    .i_rd_data       (o_rd_data),
    .i_ok            (o_ok),
    .i_last_error    (o_last_error),
    .i_fill_count    (o_fill_count),
    .i_is_empty_flag (o_is_empty_flag),
    .i_is_full_flag  (o_is_full_flag)
);
